[design/region_address_translation_table_assert.svh]
// Assertion macros used by the port-level checker of the region translation table.
`ifndef REGION_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH
`define REGION_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define RAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region table check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define RAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region table check failed");

`endif

[design/rat_pkg.sv]
// Types, codes and helpers shared by the region translation table modules.
package rat_pkg;

    // Default number of region slots.
    localparam int RAT_SLOTS = 16;

    // Field widths. Sizes are kept one bit wider than the port, since a size
    // close to the top of the 41-bit range rounds up to exactly 2^41.
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 41;
    localparam int SIZE_IW  = SIZE_W + 1;
    localparam int PAGE_LSB = 12;

    localparam logic [ADDR_W-1:0]  POOL_START = 64'hFFFF_B000_0000_0000;
    localparam logic [SIZE_IW-1:0] PAGE_BYTES = SIZE_IW'(4096);

    // Operation codes.
    typedef enum logic [2:0] {
        FN_TRACK   = 3'd0,
        FN_ALLOC   = 3'd1,
        FN_FREE    = 3'd2,
        FN_XLATE   = 3'd3,
        FN_REVERSE = 3'd4
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_OFFSET,
        S_RESOLVE
    } state_t;

    // Request broadcast to every cell while a search runs.
    typedef struct packed {
        func_t             func;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] host;
    } req_t;

    // Search token that walks the cell row. The slot indexes travel beside it.
    typedef struct packed {
        logic               busy;
        logic               exact;
        logic               any;
        logic               free_found;
        logic [ADDR_W-1:0]  gbase;
        logic [ADDR_W-1:0]  hbase;
        logic [SIZE_IW-1:0] size;
    } tok_t;

    // Slot write command, applied to the cell whose index matches.
    typedef struct packed {
        logic               en;
        logic               set;
        logic [ADDR_W-1:0]  gbase;
        logic [ADDR_W-1:0]  hbase;
        logic [SIZE_IW-1:0] size;
    } wr_t;

    // Round a size up to a whole number of pages.
    function automatic logic [SIZE_IW-1:0] page_align(input logic [SIZE_W-1:0] sz);
        logic [SIZE_IW-1:0] sum;
        sum = {1'b0, sz} + (PAGE_BYTES - SIZE_IW'(1));
        return {sum[SIZE_IW-1:PAGE_LSB], {PAGE_LSB{1'b0}}};
    endfunction

endpackage

[design/region_address_translation_table.sv]
// Top level of the region address translation table.
//
// Request channel (req_valid / req_stall) carries one beat per operation:
// func, guest_addr, host_addr and req_size. Response channel (rsp_valid /
// rsp_stall) returns one beat per request: status, region_base, host_result
// and region_size. Operations are track, allocate, free, translate and
// reverse lookup; status is ok, not found or table full.
// The slots sit in a row of cells. A search token enters the first cell and
// moves one cell per cycle, picking up the lowest exact hit, the lowest range
// hit and the lowest free slot, so the row length sets the timing.
// One request is in flight at a time, so a new request is taken only after the
// previous one has passed through the search, offset and resolve steps.
// The response sits in an output register: a request may be taken while an
// earlier response still waits. If the receiver stalls, the finished result
// is held back in the last step until the previous response is taken.
// Reset clears all slot valid bits and sets the allocation pointer to
// 0xFFFFB00000000000; the block takes requests in the first cycle after it.
module region_address_translation_table #(
    parameter int REGION_SLOTS = rat_pkg::RAT_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [2:0]                    func,
    input  logic [rat_pkg::ADDR_W-1:0]    guest_addr,
    input  logic [rat_pkg::ADDR_W-1:0]    host_addr,
    input  logic [rat_pkg::SIZE_W-1:0]    req_size,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic [rat_pkg::ADDR_W-1:0]    region_base,
    output logic [rat_pkg::ADDR_W-1:0]    host_result,
    output logic [rat_pkg::SIZE_W-1:0]    region_size
);
    import rat_pkg::*;

    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

    req_t             req;
    wr_t              wr;
    logic [IDX_W-1:0] wr_idx;

    // Token links between neighboring cells, one more than the cell count.
    tok_t             tok_link      [REGION_SLOTS+1];
    logic [IDX_W-1:0] hit_idx_link  [REGION_SLOTS+1];
    logic [IDX_W-1:0] free_idx_link [REGION_SLOTS+1];

    assign hit_idx_link[0]  = '0;
    assign free_idx_link[0] = '0;

    // Sequencer.
    rat_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .guest_addr    (guest_addr),
        .host_addr     (host_addr),
        .req_size      (req_size),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .region_base   (region_base),
        .host_result   (host_result),
        .region_size   (region_size),
        .req           (req),
        .tok_head      (tok_link[0]),
        .tok_tail      (tok_link[REGION_SLOTS]),
        .hit_idx_tail  (hit_idx_link[REGION_SLOTS]),
        .free_idx_tail (free_idx_link[REGION_SLOTS]),
        .wr            (wr),
        .wr_idx        (wr_idx)
    );

    // Row of slot cells.
    for (genvar g = 0; g < REGION_SLOTS; g++)
    begin : g_cell
        rat_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req          (req),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .tok_in       (tok_link[g]),
            .hit_idx_in   (hit_idx_link[g]),
            .free_idx_in  (free_idx_link[g]),
            .tok_out      (tok_link[g+1]),
            .hit_idx_out  (hit_idx_link[g+1]),
            .free_idx_out (free_idx_link[g+1])
        );
    end

endmodule

[design/rat_cell.sv]
// One slot of the region table together with its stage of the search token.
module rat_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rat_pkg::req_t        req,
    input  rat_pkg::wr_t         wr,
    input  logic [IDX_W-1:0]     wr_idx,
    input  rat_pkg::tok_t        tok_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     free_idx_in,
    output rat_pkg::tok_t        tok_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     free_idx_out
);
    import rat_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               valid_reg;
    logic [ADDR_W-1:0]  gbase_reg;
    logic [ADDR_W-1:0]  hbase_reg;
    logic [SIZE_IW-1:0] size_reg;

    tok_t               tok_reg, tok_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               key_hit;
    logic               range_hit;
    logic [ADDR_W-1:0]  diff;
    logic               wr_here;

    assign wr_here = wr.en && (wr_idx == MY_IDX);

    // Slot valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= wr.set;
        end
    end

    // Slot contents, written only when a region is recorded.
    always_ff @(posedge clk)
    begin
        if (wr_here && wr.set)
        begin
            gbase_reg <= wr.gbase;
            hbase_reg <= wr.hbase;
            size_reg  <= wr.size;
        end
    end

    // Match terms: exact key (host base for reverse lookup) and range.
    always_comb
    begin
        diff = req.key - gbase_reg;
        if (req.func == FN_REVERSE)
        begin
            key_hit = valid_reg && (hbase_reg == req.host);
        end
        else
        begin
            key_hit = valid_reg && (gbase_reg == req.key);
        end
        range_hit = valid_reg && (req.func == FN_XLATE)
                    && (diff < {{(ADDR_W - SIZE_IW){1'b0}}, size_reg});
    end

    // Token update: an earlier exact hit wins, then the first range hit.
    always_comb
    begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (!tok_in.exact && key_hit)
        begin
            tok_next.exact = 1'b1;
            tok_next.any   = 1'b1;
            tok_next.gbase = gbase_reg;
            tok_next.hbase = hbase_reg;
            tok_next.size  = size_reg;
            hit_idx_next   = MY_IDX;
        end
        else if (!tok_in.any && range_hit)
        begin
            tok_next.any   = 1'b1;
            tok_next.gbase = gbase_reg;
            tok_next.hbase = hbase_reg;
            tok_next.size  = size_reg;
            hit_idx_next   = MY_IDX;
        end
        if (!tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            free_idx_next       = MY_IDX;
        end
    end

    // Token and slot indexes move to the neighbor every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            tok_reg      <= tok_next;
            hit_idx_reg  <= hit_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

[design/rat_ctrl.sv]
// Sequencer: takes a request, runs the search token, then answers and writes back.
module rat_ctrl #(
    parameter int IDX_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [2:0]                    func,
    input  logic [rat_pkg::ADDR_W-1:0]    guest_addr,
    input  logic [rat_pkg::ADDR_W-1:0]    host_addr,
    input  logic [rat_pkg::SIZE_W-1:0]    req_size,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic [rat_pkg::ADDR_W-1:0]    region_base,
    output logic [rat_pkg::ADDR_W-1:0]    host_result,
    output logic [rat_pkg::SIZE_W-1:0]    region_size,
    output rat_pkg::req_t                 req,
    output rat_pkg::tok_t                 tok_head,
    input  rat_pkg::tok_t                 tok_tail,
    input  logic [IDX_W-1:0]              hit_idx_tail,
    input  logic [IDX_W-1:0]              free_idx_tail,
    output rat_pkg::wr_t                  wr,
    output logic [IDX_W-1:0]              wr_idx
);
    import rat_pkg::*;

    state_t             state_reg, state_next;
    logic               launch_reg;
    logic [ADDR_W-1:0]  pool_reg, pool_next;
    logic               rsp_valid_reg, rsp_valid_next;

    func_t              func_reg;
    logic [ADDR_W-1:0]  key_reg;
    logic [ADDR_W-1:0]  host_reg;
    logic [SIZE_IW-1:0] size_reg;

    tok_t               res_tok_reg;
    logic [IDX_W-1:0]   res_hit_idx_reg;
    logic [IDX_W-1:0]   res_free_idx_reg;
    logic [ADDR_W-1:0]  offset_reg;

    logic [1:0]         status_reg, status_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]  host_res_reg, host_res_next;
    logic [SIZE_IW-1:0] rsize_reg, rsize_next;

    logic               accept;
    logic               finish;
    logic [SIZE_W-1:0]  size_in;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    // An allocation of zero bytes takes one page.
    assign size_in   = ((func_t'(func) == FN_ALLOC) && (req_size == '0))
                       ? SIZE_W'(PAGE_BYTES) : req_size;

    // Broadcast request and head of the token row.
    always_comb
    begin
        req.func            = func_reg;
        req.key             = key_reg;
        req.host            = host_reg;
        tok_head            = '0;
        tok_head.busy       = launch_reg;
    end

    // Next state, write-back command and result.
    always_comb
    begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        rsp_valid_next = rsp_valid_reg;
        finish         = 1'b0;
        wr             = '0;
        wr_idx         = res_hit_idx_reg;
        status_next    = STS_MISS;
        base_next      = '0;
        host_res_next  = '0;
        rsize_next     = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tok_tail.busy)
                begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    finish         = 1'b1;
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Decode the operation against the search outcome.
        unique case (func_reg) inside
            FN_TRACK, FN_ALLOC:
            begin
                if (res_tok_reg.exact || res_tok_reg.free_found)
                begin
                    wr_idx        = res_tok_reg.exact ? res_hit_idx_reg : res_free_idx_reg;
                    wr.en         = finish;
                    wr.set        = 1'b1;
                    wr.gbase      = key_reg;
                    wr.hbase      = host_reg;
                    wr.size       = size_reg;
                    status_next   = STS_OK;
                    base_next     = key_reg;
                    host_res_next = host_reg;
                    rsize_next    = size_reg;
                    if (finish && (func_reg == FN_ALLOC))
                    begin
                        pool_next = key_reg + {{(ADDR_W - SIZE_IW){1'b0}}, size_reg};
                    end
                end
                else
                begin
                    status_next = STS_FULL;
                end
            end
            FN_FREE:
            begin
                if (res_tok_reg.exact)
                begin
                    wr.en         = finish;
                    wr.set        = 1'b0;
                    status_next   = STS_OK;
                    base_next     = res_tok_reg.gbase;
                    host_res_next = res_tok_reg.hbase;
                    rsize_next    = res_tok_reg.size;
                end
            end
            FN_XLATE:
            begin
                if (res_tok_reg.any)
                begin
                    status_next   = STS_OK;
                    base_next     = res_tok_reg.gbase;
                    host_res_next = res_tok_reg.hbase + offset_reg;
                    rsize_next    = res_tok_reg.size;
                end
            end
            FN_REVERSE:
            begin
                if (res_tok_reg.exact)
                begin
                    status_next   = STS_OK;
                    base_next     = res_tok_reg.gbase;
                    host_res_next = host_reg;
                    rsize_next    = res_tok_reg.size;
                end
            end
            default:
            begin
                status_next = STS_MISS;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            pool_reg      <= POOL_START;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= accept;
            pool_reg      <= pool_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture; an allocation takes its base from the pool pointer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            key_reg  <= (func_t'(func) == FN_ALLOC) ? pool_reg : guest_addr;
            host_reg <= host_addr;
            size_reg <= page_align(size_in);
        end
    end

    // Token capture at the end of the row, then the translation offset.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEARCH) && tok_tail.busy)
        begin
            res_tok_reg      <= tok_tail;
            res_hit_idx_reg  <= hit_idx_tail;
            res_free_idx_reg <= free_idx_tail;
        end
        if (state_reg == S_OFFSET)
        begin
            offset_reg <= key_reg - res_tok_reg.gbase;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg   <= status_next;
            base_reg     <= base_next;
            host_res_reg <= host_res_next;
            rsize_reg    <= rsize_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign region_base = base_reg;
    assign host_result = host_res_reg;
    assign region_size = rsize_reg[SIZE_W-1:0];

endmodule

[design/rat_checker.sv]
// Port-level checks of the region translation table and their bind.
`include "region_address_translation_table_assert.svh"

module rat_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic [2:0]                    func,
    input logic [rat_pkg::ADDR_W-1:0]    guest_addr,
    input logic [rat_pkg::ADDR_W-1:0]    host_addr,
    input logic [rat_pkg::SIZE_W-1:0]    req_size,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [1:0]                    status,
    input logic [rat_pkg::ADDR_W-1:0]    region_base,
    input logic [rat_pkg::ADDR_W-1:0]    host_result,
    input logic [rat_pkg::SIZE_W-1:0]    region_size
);
    import rat_pkg::*;

    // A stalled response beat keeps its status, base and size.
    `RAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(status) && $stable(region_base) && $stable(region_size))

    // One request at a time: a taken request closes the request channel.
    `RAT_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

    // A failed operation reports nothing but its status.
    `RAT_ASSERT_NOW(a_fail_zero, rsp_valid && (status != STS_OK),
        (region_base == '0) && (host_result == '0) && (region_size == '0))

    // Reported sizes are whole pages.
    `RAT_ASSERT_NOW(a_size_paged, rsp_valid && (status == STS_OK),
        region_size[PAGE_LSB-1:0] == '0)

endmodule

bind region_address_translation_table rat_checker u_rat_checker (.*);

[tb/region_address_translation_table_checker.sv]
// Response checker for the region translation table: predicts and compares each response.
module region_address_translation_table_checker #(
    parameter int SLOTS = rat_pkg::RAT_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_stall,
    input  logic [2:0]                 func,
    input  logic [rat_pkg::ADDR_W-1:0] guest_addr,
    input  logic [rat_pkg::ADDR_W-1:0] host_addr,
    input  logic [rat_pkg::SIZE_W-1:0] req_size,
    input  logic                       rsp_valid,
    input  logic                       rsp_stall,
    input  logic [1:0]                 status,
    input  logic [rat_pkg::ADDR_W-1:0] region_base,
    input  logic [rat_pkg::ADDR_W-1:0] host_result,
    input  logic [rat_pkg::SIZE_W-1:0] region_size,
    output int                         mismatches,
    output int                         outstanding,
    output int                         compared,
    output int                         full_seen,
    output int                         miss_seen
);
    import rat_pkg::*;

    // One slot of the predicted table. The size keeps one extra bit, since
    // rounding up can carry past the 41-bit port width.
    typedef struct packed {
        logic               live;
        logic [ADDR_W-1:0]  gbase;
        logic [ADDR_W-1:0]  hbase;
        logic [SIZE_IW-1:0] span;
    } region_t;

    // One predicted response beat.
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] host;
        logic [SIZE_W-1:0] size;
    } outcome_t;

    region_t           regions [SLOTS];
    logic [ADDR_W-1:0] pool_ptr;
    outcome_t          awaited_results [$];
    int                fail_count;
    int                cmp_count;
    int                full_count;
    int                miss_count;

    // Round a byte count up to whole 4 KiB pages.
    function automatic logic [SIZE_IW-1:0] to_pages(input logic [SIZE_W-1:0] sz);
        return ({1'b0, sz} + SIZE_IW'(12'hFFF)) & ~SIZE_IW'(12'hFFF);
    endfunction

    // Lowest live slot whose guest base equals the key, or -1.
    function automatic int exact_slot(input logic [ADDR_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (regions[i].live && regions[i].gbase == key)
                return i;
        return -1;
    endfunction

    // Lowest empty slot, or -1 when every slot is live.
    function automatic int first_free();
        for (int i = 0; i < SLOTS; i++)
            if (!regions[i].live)
                return i;
        return -1;
    endfunction

    // Apply one request to the predicted table and return the response it gives.
    function automatic outcome_t run_table_op(input func_t op,
                                              input logic [ADDR_W-1:0] gaddr,
                                              input logic [ADDR_W-1:0] haddr,
                                              input logic [SIZE_W-1:0] rsize);
        outcome_t           res;
        int                 hit;
        logic [ADDR_W-1:0]  base;
        logic [SIZE_IW-1:0] span;
        res = '{status: STS_MISS, base: '0, host: '0, size: '0};
        hit = -1;
        case (op) inside
            FN_TRACK, FN_ALLOC:
            begin
                // Allocation takes its base from the pool pointer; a zero size means one page.
                if (op == FN_ALLOC)
                begin
                    base = pool_ptr;
                    span = to_pages((rsize == '0) ? SIZE_W'(4096) : rsize);
                end
                else
                begin
                    base = gaddr;
                    span = to_pages(rsize);
                end
                // A base already present is overwritten in place.
                hit = exact_slot(base);
                if (hit < 0)
                    hit = first_free();
                if (hit < 0)
                    res.status = STS_FULL;
                else
                begin
                    regions[hit] = '{1'b1, base, haddr, span};
                    if (op == FN_ALLOC)
                        pool_ptr = base + ADDR_W'(span);
                    res = '{STS_OK, base, haddr, span[SIZE_W-1:0]};
                end
            end
            FN_FREE:
            begin
                hit = exact_slot(gaddr);
                if (hit >= 0)
                begin
                    regions[hit].live = 1'b0;
                    res = '{STS_OK, regions[hit].gbase, regions[hit].hbase,
                            regions[hit].span[SIZE_W-1:0]};
                end
            end
            FN_XLATE:
            begin
                // Exact base first, then the lowest slot whose range covers the address.
                // The offset test wraps, so a region crossing 2^64 still matches.
                hit = exact_slot(gaddr);
                for (int k = 0; k < SLOTS && hit < 0; k++)
                    if (regions[k].live &&
                        (gaddr - regions[k].gbase) < ADDR_W'(regions[k].span))
                        hit = k;
                if (hit >= 0)
                    res = '{STS_OK, regions[hit].gbase,
                            regions[hit].hbase + (gaddr - regions[hit].gbase),
                            regions[hit].span[SIZE_W-1:0]};
            end
            FN_REVERSE:
            begin
                for (int k = 0; k < SLOTS && hit < 0; k++)
                    if (regions[k].live && regions[k].hbase == haddr)
                        hit = k;
                if (hit >= 0)
                    res = '{STS_OK, regions[hit].gbase, haddr, regions[hit].span[SIZE_W-1:0]};
            end
            default:
            begin
                res.status = STS_MISS;
            end
        endcase
        return res;
    endfunction

    // Compare response beats against the oldest prediction, then predict accepted requests.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                regions[i] = '0;
            pool_ptr = POOL_START;
            awaited_results.delete();
            fail_count = 0;
            cmp_count  = 0;
            full_count = 0;
            miss_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = '{status_t'(status), region_base, host_result, region_size};
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response beat with nothing awaited: status %0d base %h",
                                 $realtime, got.status, got.base);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    cmp_count++;
                    if (got.status !== want.status || got.base !== want.base ||
                        got.host !== want.host || got.size !== want.size)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: response %0d mismatch", $realtime, cmp_count);
                            $display("  expected status %0d base %h host %h size %h",
                                     want.status, want.base, want.host, want.size);
                            $display("  actual   status %0d base %h host %h size %h",
                                     got.status, got.base, got.host, got.size);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = run_table_op(func_t'(func), guest_addr, host_addr, req_size);
                if (want.status == STS_FULL)
                    full_count++;
                if (want.status == STS_MISS)
                    miss_count++;
                awaited_results.push_back(want);
            end
        end
        mismatches  <= fail_count;
        outstanding <= awaited_results.size();
        compared    <= cmp_count;
        full_seen   <= full_count;
        miss_seen   <= miss_count;
    end

endmodule

[tb/region_address_translation_table_tb.sv]
// Testbench top for the region address translation table: clock, reset, stimulus and verdict.
module region_address_translation_table_tb;
    import rat_pkg::*;

    localparam int                RANDOM_ITEMS = 1900;
    localparam int                HOLD_START   = 3000;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                DRAIN_CYCLES = 100;
    localparam logic [ADDR_W-1:0] ALL_ONES     = '1;
    localparam logic [SIZE_W-1:0] SIZE_TOP     = 41'h100_0000_0000;

    // Live regions as the stimulus sees them, used to aim requests at real entries.
    typedef struct {
        logic [ADDR_W-1:0] gbase;
        logic [ADDR_W-1:0] hbase;
        logic [SIZE_W-1:0] size;
    } known_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [2:0]        func;
    logic [ADDR_W-1:0] guest_addr;
    logic [ADDR_W-1:0] host_addr;
    logic [SIZE_W-1:0] req_size;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [1:0]        status;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] host_result;
    logic [SIZE_W-1:0] region_size;

    int                mismatches;
    int                outstanding;
    int                compared;
    int                full_seen;
    int                miss_seen;

    known_t            known [$];
    logic [ADDR_W-1:0] pool_next;
    int                op_count [5];
    bit                no_idle;

    always #5 clk = ~clk;

    region_address_translation_table #(
        .REGION_SLOTS (RAT_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .guest_addr  (guest_addr),
        .host_addr   (host_addr),
        .req_size    (req_size),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .region_base (region_base),
        .host_result (host_result),
        .region_size (region_size)
    );

    region_address_translation_table_checker #(
        .SLOTS (RAT_SLOTS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .guest_addr  (guest_addr),
        .host_addr   (host_addr),
        .req_size    (req_size),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .region_base (region_base),
        .host_result (host_result),
        .region_size (region_size),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared),
        .full_seen   (full_seen),
        .miss_seen   (miss_seen)
    );

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(0, 255)), $urandom};
    endfunction

    // Idle cycles before a request beat: mostly none or a few, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request sizes: mostly small, with zero, whole pages and the top of the range mixed in.
    // Allocations lean toward the largest size so the pool pointer wraps during the run.
    function automatic logic [SIZE_W-1:0] pick_size(input bit for_alloc);
        int r;
        r = $urandom_range(0, 99);
        if (for_alloc && $urandom_range(0, 1) == 1)
            return SIZE_TOP;
        if (r < 10)
            return '0;
        if (r < 55)
            return SIZE_W'($urandom_range(1, 65536));
        if (r < 65)
            return SIZE_W'($urandom_range(1, 64)) << 12;
        if (r < 80)
            return SIZE_W'(rand40());
        if (r < 90)
            return SIZE_TOP;
        return SIZE_TOP - SIZE_W'($urandom_range(0, 8191));
    endfunction

    function automatic int find_known(input logic [ADDR_W-1:0] key);
        foreach (known[i])
            if (known[i].gbase == key)
                return i;
        return -1;
    endfunction

    // Guest base for a track: reuse of a live base, the next pool base, low pages,
    // the very top of the address space, or anything at all.
    function automatic logic [ADDR_W-1:0] pick_guest_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20 && known.size() != 0)
            return known[$urandom_range(0, known.size() - 1)].gbase;
        if (r < 30)
            return pool_next;
        if (r < 55)
            return ADDR_W'($urandom_range(0, 1023)) << 12;
        if (r < 65)
            return ALL_ONES - ADDR_W'($urandom_range(0, 1 << 20));
        if (r < 70)
            return ADDR_W'($urandom_range(0, 65535));
        return rand64();
    endfunction

    // Host base: often shared with a live region so reverse lookups see duplicates.
    function automatic logic [ADDR_W-1:0] pick_host();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 && known.size() != 0)
            return known[$urandom_range(0, known.size() - 1)].hbase;
        if (r < 20)
            return '0;
        if (r < 25)
            return ALL_ONES;
        return rand64();
    endfunction

    // Translate address: inside a live region, on its edges, in the pool area, or random.
    function automatic logic [ADDR_W-1:0] pick_probe();
        int     r;
        known_t k;
        r = $urandom_range(0, 99);
        if (known.size() != 0 && r < 65)
        begin
            k = known[$urandom_range(0, known.size() - 1)];
            if (r < 12)
                return k.gbase;
            if (r < 18)
                return k.gbase - 1;
            if (r < 24)
                return k.gbase + ADDR_W'(k.size);
            if (k.size == '0)
                return k.gbase;
            return k.gbase + (ADDR_W'(rand40()) % ADDR_W'(k.size));
        end
        if (r < 80)
            return POOL_START + (rand64() >> 17);
        return rand64();
    endfunction

    // Send one request beat and keep the view of live regions in step with it.
    task automatic issue(input func_t fn, input logic [ADDR_W-1:0] g,
                         input logic [ADDR_W-1:0] h, input logic [SIZE_W-1:0] s);
        int                gap;
        int                idx;
        bit                took;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] asz;
        base = (fn == FN_ALLOC) ? pool_next : g;
        asz  = (fn == FN_ALLOC && s == '0) ? SIZE_W'(4096) : s;
        asz  = (asz + SIZE_W'(12'hFFF)) & ~SIZE_W'(12'hFFF);
        idx  = find_known(base);
        took = 1'b1;
        if (fn == FN_TRACK || fn == FN_ALLOC)
        begin
            if (idx >= 0)
                known[idx] = known_t'{base, h, asz};
            else if (known.size() < RAT_SLOTS)
                known.push_back(known_t'{base, h, asz});
            else
                took = 1'b0;
            if (fn == FN_ALLOC && took)
                pool_next = base + ADDR_W'(asz);
        end
        else if (fn == FN_FREE && idx >= 0)
        begin
            known.delete(idx);
        end

        // Drive the beat after an optional gap and hold it until it is taken.
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        func       <= fn;
        guest_addr <= g;
        host_addr  <= h;
        req_size   <= s;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        op_count[int'(fn)]++;
    endtask

    // Response side: random stalls, long clear stretches, and one long hold-off
    // that lets the block back up onto its request channel.
    initial
    begin : rsp_side
        int r;
        int span;
        int spent;
        bit held;
        rsp_stall = 1'b0;
        spent     = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && spent >= HOLD_START)
            begin
                rsp_stall <= 1'b1;
                span = HOLD_CYCLES;
                held = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(1, 8);
                end
                else if (r < 75)
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else if (r < 88)
                begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(20, 120);
                end
                else if (r < 97)
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(4, 15);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(30, 60);
                end
            end
            repeat (span) @(posedge clk);
            spent += span;
        end
    end

    // Main stimulus and verdict.
    initial
    begin : stimulus
        int r;
        int free_w;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        func       = FN_TRACK;
        guest_addr = '0;
        host_addr  = '0;
        req_size   = '0;
        pool_next  = POOL_START;
        no_idle    = 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: misses on an empty table.
        issue(FN_XLATE, '0, '0, '0);
        issue(FN_FREE, '0, '0, '0);
        // Allocation with size zero, one byte and just over a page.
        issue(FN_ALLOC, '0, '0, '0);
        issue(FN_ALLOC, '0, ALL_ONES, SIZE_W'(1));
        issue(FN_ALLOC, '0, 64'h5555_5555_5555_5555, SIZE_W'(4097));
        // A zero-size region matches only on its exact base.
        issue(FN_TRACK, '0, 64'h1000, '0);
        issue(FN_XLATE, '0, '0, '0);
        issue(FN_XLATE, 64'd1, '0, '0);
        // A region that wraps past the top of the address space.
        issue(FN_TRACK, 64'hFFFF_FFFF_FFFF_F000, 64'hAAAA_AAAA_AAAA_AAAA, SIZE_W'(32'h2000));
        issue(FN_XLATE, 64'h800, '0, '0);
        issue(FN_XLATE, ALL_ONES, '0, '0);
        // Largest size, a duplicate host base, then an overwrite of the same guest base.
        issue(FN_TRACK, 64'h1_0000_0000, ALL_ONES, SIZE_TOP);
        issue(FN_REVERSE, '0, ALL_ONES, '0);
        issue(FN_TRACK, 64'h1_0000_0000, 64'h1234, SIZE_W'(123));
        issue(FN_XLATE, 64'h1_0000_0ABC, '0, '0);
        // Free by exact base, then reuse of the freed slot.
        issue(FN_FREE, POOL_START, '0, '0);
        issue(FN_ALLOC, '0, '0, SIZE_TOP);
        // Fill the table, then a track and an allocate against a full table.
        while (known.size() < RAT_SLOTS)
            issue(FN_TRACK, 64'h4000_0000 + (ADDR_W'(known.size()) << 20), rand64(),
                  SIZE_W'(4096));
        issue(FN_TRACK, 64'h7000_0000, rand64(), SIZE_W'(4096));
        issue(FN_ALLOC, '0, rand64(), SIZE_W'(8192));

        // Random part: mostly requests aimed at live regions, some noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n % 400) < 60;
            r = $urandom_range(0, 99);
            free_w = (known.size() >= RAT_SLOTS) ? 25 : ((known.size() >= 12) ? 15 : 7);
            if (r < 20)
                issue(FN_TRACK, pick_guest_base(), pick_host(), pick_size(1'b0));
            else if (r < 35)
                issue(FN_ALLOC, rand64(), pick_host(), pick_size(1'b1));
            else if (r < 35 + free_w)
            begin
                r = $urandom_range(0, 99);
                if (r < 70 && known.size() != 0)
                    issue(FN_FREE, known[$urandom_range(0, known.size() - 1)].gbase,
                          rand64(), pick_size(1'b0));
                else if (r < 80)
                    issue(FN_FREE, pool_next, rand64(), pick_size(1'b0));
                else
                    issue(FN_FREE, rand64(), rand64(), pick_size(1'b0));
            end
            else if (r < 80)
                issue(FN_XLATE, pick_probe(), rand64(), pick_size(1'b0));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65 && known.size() != 0)
                    issue(FN_REVERSE, rand64(),
                          known[$urandom_range(0, known.size() - 1)].hbase, pick_size(1'b0));
                else if (r < 70)
                    issue(FN_REVERSE, rand64(), '0, pick_size(1'b0));
                else if (r < 75)
                    issue(FN_REVERSE, rand64(), ALL_ONES, pick_size(1'b0));
                else
                    issue(FN_REVERSE, rand64(), rand64(), pick_size(1'b0));
            end
        end
        req_valid <= 1'b0;

        // Let every awaited response arrive, then watch a while for stray beats.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d track, %0d allocate, %0d free, %0d translate, %0d reverse requests.",
                 op_count[FN_TRACK], op_count[FN_ALLOC], op_count[FN_FREE],
                 op_count[FN_XLATE], op_count[FN_REVERSE]);
        $display("Checked %0d responses: %0d not found, %0d table full, %0d mismatches.",
                 compared, miss_seen, full_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("[region_address_translation_table] OK");
        else
            $display("[region_address_translation_table] ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #12_000_000;
        $display("Run timed out with %0d responses still awaited.", outstanding);
        $display("[region_address_translation_table] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/rat_pkg.sv
design/rat_cell.sv
design/rat_ctrl.sv
design/region_address_translation_table.sv
design/rat_checker.sv
tb/region_address_translation_table_checker.sv
tb/region_address_translation_table_tb.sv
